[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge out of reset
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ars_pkg.sv]
// types and constants of the address range search block
package ars_pkg;

  localparam int MAX_RANGES = 64;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int ADDR_W     = 64;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic              op;
    logic [5:0]        entry_index;
    logic [ADDR_W-1:0] entry_first;
    logic [ADDR_W-1:0] entry_size_m1;
    logic [ADDR_W-1:0] search_address;
  } in_word_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] range_index;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic write_entry;  // store one table entry
    logic start;        // latch address, set bounds, issue first probe
    logic step;         // compare current probe, move bounds
    logic load_out;     // move result into output register
  } ars_cmd_t;

  typedef struct packed {
    logic empty;  // saturated range count is zero
    logic last;   // current probe ends the search
  } ars_status_t;

endpackage

[hw/rtl/ars_dpath.sv]
// datapath: range table memory, search bounds, compare and output register
`include "assert_macros.svh"

module ars_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ars_pkg::ars_cmd_t    cmd,
  output ars_pkg::ars_status_t status,
  input  ars_pkg::in_word_t    in_data,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_data,
  output ars_pkg::out_word_t   out_data
);
  import ars_pkg::*;

  logic [ADDR_W-1:0] first_mem [MAX_RANGES];
  logic [ADDR_W-1:0] size_mem  [MAX_RANGES];
  logic [ADDR_W-1:0] first_r;
  logic [ADDR_W-1:0] size_r;

  logic [6:0]        count_r;
  logic [CNT_W-1:0]  n_sat;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [IDX_W-1:0]  cur_r;
  logic [ADDR_W-1:0] addr_r;
  logic              res_hit_r;
  logic [CNT_W-1:0]  res_idx_r;
  out_word_t         out_r;

  logic [CNT_W-1:0]  p;
  logic [CNT_W-1:0]  prb_nxt;
  logic [ADDR_W-1:0] diff;
  logic              lt;
  logic              in_range;
  logic              hit;
  logic [IDX_W-1:0]  rd_addr;

  // zero-based probe from one-based bounds: (lo + hi - 2) / 2
  function automatic logic [IDX_W-1:0] mid_idx(input logic [CNT_W-1:0] lo,
                                               input logic [CNT_W-1:0] hi);
    logic [CNT_W:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} - (CNT_W+1)'(2);
    return sum[IDX_W:1];
  endfunction

  assign n_sat = (count_r > 7'(MAX_RANGES)) ? CNT_W'(MAX_RANGES) : CNT_W'(count_r);

  assign p        = {1'b0, cur_r};
  assign lt       = addr_r < first_r;
  assign diff     = addr_r - first_r;
  assign in_range = diff <= size_r;
  assign hit      = !lt && in_range;

  always_comb begin
    if (lt) begin
      lo_nxt  = lo_r;
      hi_nxt  = p;
      prb_nxt = p;
    end else begin
      lo_nxt  = p + CNT_W'(2);
      hi_nxt  = hi_r;
      prb_nxt = p + CNT_W'(1);
    end
  end

  assign status.last  = hit || (lo_nxt > hi_nxt);
  assign status.empty = (n_sat == '0);

  assign rd_addr = cmd.start ? mid_idx(CNT_W'(1), n_sat) : mid_idx(lo_nxt, hi_nxt);

  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      first_mem[in_data.entry_index[IDX_W-1:0]] <= in_data.entry_first;
      size_mem[in_data.entry_index[IDX_W-1:0]]  <= in_data.entry_size_m1;
    end
    first_r <= first_mem[rd_addr];
    size_r  <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lo_r      <= CNT_W'(1);
      hi_r      <= n_sat;
      cur_r     <= rd_addr;
      addr_r    <= in_data.search_address;
      res_hit_r <= 1'b0;
      res_idx_r <= '0;
    end else if (cmd.step) begin
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      cur_r     <= rd_addr;
      res_hit_r <= hit;
      res_idx_r <= hit ? p : prb_nxt;
    end
    if (cmd.load_out) begin
      out_r.hit         <= res_hit_r;
      out_r.range_index <= 7'(res_idx_r);
    end
  end

  assign out_data = out_r;

  `ASSERT_NOW(a_bounds_open, cmd.step, (lo_r <= hi_r) && (hi_r <= n_sat),
              "probe taken with empty or oversized bounds")
  `ASSERT_NOW(a_result_range, cmd.load_out, res_idx_r <= n_sat,
              "result index beyond searched count")
  `ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.write_entry, cmd.start, cmd.step}),
              "conflicting datapath commands")

endmodule

[hw/rtl/ars_ctrl.sv]
// controller: input acceptance, search sequencing and output valid
`include "assert_macros.svh"

module ars_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ars_pkg::ars_status_t status,
  output ars_pkg::ars_cmd_t    cmd
);
  import ars_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_SEARCH) begin
            cmd.start = 1'b1;
            state_nxt = status.empty ? ST_FINISH : ST_SEARCH;
          end else begin
            cmd.write_entry = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `ASSERT_NOW(a_load_free, cmd.load_out, !out_valid_r || out_ready,
              "result loaded over an untaken word")
  `ASSERT_NEXT(a_last_finish, (state_r == ST_SEARCH) && status.last, state_r == ST_FINISH,
               "search end not followed by result stage")
  `ASSERT_NEXT(a_load_valid, cmd.load_out, out_valid_r,
               "loaded result not presented")

endmodule

[hw/rtl/address_range_search.sv]
// address range search: binary search over a table of sorted address ranges
// a write word is stored from idle, and write words can follow every cycle while no search is under way
// a search word probes one entry per cycle, bounded by the table's single read port
// (at most 7 probes for 64 ranges); its result is then loaded into the output register
// once the output slot is free, and no new word is taken until that load is done
// synchronous active-low reset clears the range count and control; table is unset
module address_range_search (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ars_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ars_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);
  import ars_pkg::*;

  ars_cmd_t    cmd;
  ars_status_t status;

  assign cfg_ready = 1'b1;

  ars_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ars_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

[bench/testbench.sv]
// self-checking bench for the address range search block: sorted tables, searches, count limits
module testbench;
  import ars_pkg::*;

  localparam int HOLD_CYCLES  = 300;   // long output hold-off that backs up the input
  localparam int SETTLE       = 12;    // quiet clocks after every answer is back, before the next step
  localparam int STALL_LIMIT  = 4000;  // cycles with no handshake before giving up
  localparam int TARGET_WORDS = 1900;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [6:0] cfg_data = '0;

  address_range_search u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // words waiting for the driver and answers waiting for the block
  in_word_t  pending_words[$];
  out_word_t expected_answers[$];

  // predictor state, updated at accepted handshakes
  logic [63:0] table_first [MAX_RANGES];
  logic [63:0] table_size_m1 [MAX_RANGES];
  int unsigned search_count = 0;

  // stimulus-side view of the table as queued
  logic [63:0] plan_first [MAX_RANGES];
  logic [63:0] plan_size_m1 [MAX_RANGES];
  bit          plan_written [MAX_RANGES];

  int  errors = 0;
  int  words_queued = 0;
  int  writes_sent = 0;
  int  searches_sent = 0;
  int  hits_seen = 0;
  int  settings_used = 0;
  bit  calm = 1'b0;
  bit  in_taken = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  holds_asked = 0;
  int  holds_served = 0;
  in_word_t  seen_word;
  out_word_t want;

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // binary search with one-based bounds, pivot (left + right - 2) / 2
  function automatic out_word_t find_range(logic [63:0] addr);
    int unsigned n, lo, hi, probe;
    out_word_t   r;
    n = (search_count > MAX_RANGES) ? MAX_RANGES : search_count;
    lo = 1;
    hi = n;
    probe = n;
    r.hit = 1'b0;
    while (lo <= hi) begin
      probe = (lo + hi - 2) / 2;
      if (probe >= MAX_RANGES) break;
      if (addr < table_first[probe]) begin
        hi = probe;
      end else if (addr - table_first[probe] <= table_size_m1[probe]) begin
        r.hit = 1'b1;
        break;
      end else begin
        lo = probe + 2;
        probe = probe + 1;
      end
    end
    r.range_index = probe[6:0];
    return r;
  endfunction

  function automatic in_word_t make_write(int idx, logic [63:0] first, logic [63:0] size_m1);
    in_word_t w;
    w.op = OP_WRITE;
    w.entry_index = idx[5:0];
    w.entry_first = first;
    w.entry_size_m1 = size_m1;
    w.search_address = rnd64();  // ignored by a write
    return w;
  endfunction

  function automatic in_word_t make_search(logic [63:0] addr);
    in_word_t w;
    w.op = OP_SEARCH;
    w.entry_index = $urandom_range(0, 63);
    w.entry_first = rnd64();
    w.entry_size_m1 = rnd64();
    w.search_address = addr;
    return w;
  endfunction

  // address near a planned range: edges, one off the edges, inside, or anywhere
  function automatic logic [63:0] pick_address(int n);
    int k;
    logic [63:0] lo_a, hi_a;
    if (n == 0) return ($urandom_range(0, 2) == 0) ? '0 : rnd64();
    k = $urandom_range(0, n - 1);
    lo_a = plan_first[k];
    hi_a = lo_a + plan_size_m1[k];
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return rnd64();
      3: return lo_a;
      4: return hi_a;
      5: return lo_a - 1;
      6: return hi_a + 1;
      default: begin
        if (plan_size_m1[k] == '1) return rnd64();
        return lo_a + rnd64() % (plan_size_m1[k] + 1);
      end
    endcase
  endfunction

  task automatic report(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task automatic push_word(in_word_t w);
    pending_words.push_back(w);
    words_queued++;
    if (w.op == OP_WRITE) begin
      plan_first[w.entry_index] = w.entry_first;
      plan_size_m1[w.entry_index] = w.entry_size_m1;
      plan_written[w.entry_index] = 1'b1;
      writes_sent++;
    end else begin
      searches_sent++;
    end
  endtask

  // sender stops until every answer is back, then lets the block settle
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_answers.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_count(int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v[6:0];
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // sorted, non-overlapping ranges, one per slot of 2**shift addresses
  task automatic build_table(int n);
    int i, shift;
    logic [63:0] slot, off, size_m1;
    case ($urandom_range(0, 2))
      0: shift = 4;
      1: shift = 20;
      default: shift = 58;
    endcase
    slot = 64'd1 << shift;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 2))
        0: off = '0;
        1: off = $urandom_range(0, 3);
        default: off = rnd64() & (slot / 2 - 1);
      endcase
      case ($urandom_range(0, 2))
        0: size_m1 = slot - 1 - off;  // runs up to the next slot
        1: size_m1 = $urandom_range(0, 3);
        default: size_m1 = rnd64() & (slot / 2 - 1);
      endcase
      push_word(make_write(i, (64'(i) << shift) + off, size_m1));
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the word until it is taken
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      gap_left = $urandom_range(1, 15) - 1;
    end else if (pending_words.size() > 0) begin
      in_data <= pending_words.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (holds_served < holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) search_count = cfg_data;
      if (in_valid && in_ready) begin
        seen_word = in_data;
        if (seen_word.op == OP_WRITE) begin
          table_first[seen_word.entry_index] = seen_word.entry_first;
          table_size_m1[seen_word.entry_index] = seen_word.entry_size_m1;
        end else begin
          expected_answers.push_back(find_range(seen_word.search_address));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          report($sformatf("result word with no search waiting: hit %b index %0d",
                           out_data.hit, out_data.range_index));
        end else begin
          want = expected_answers.pop_front();
          if (want.hit) hits_seen++;
          if (out_data.hit !== want.hit)
            report($sformatf("hit: got %b want %b", out_data.hit, want.hit));
          if (out_data.range_index !== want.range_index)
            report($sformatf("range_index: got %0d want %0d",
                             out_data.range_index, want.range_index));
        end
      end
    end
  end

  // watchdog on handshake progress
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // stimulus
  initial begin
    int  phase, count, n, ops, j, i;
    bit  ready;
    int  extremes [6];
    extremes = '{0, 1, 64, 127, 65, 63};
    for (i = 0; i < MAX_RANGES; i++) plan_written[i] = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty count after reset, a three-entry table touching both ends
    push_word(make_search('0));
    push_word(make_search('1));
    push_word(make_write(0, '0, 64'hF));
    push_word(make_write(1, 64'h100, '0));
    push_word(make_write(2, 64'hFFFF_FFFF_FFFF_FF00, 64'hFF));
    push_word(make_search(64'h100));
    wait_drained();
    set_count(3);
    push_word(make_search('0));
    push_word(make_search(64'hF));
    push_word(make_search(64'h10));
    push_word(make_search(64'hFF));
    push_word(make_search(64'h100));
    push_word(make_search(64'h101));
    push_word(make_search(64'hFFFF_FFFF_FFFF_FEFF));
    push_word(make_search(64'hFFFF_FFFF_FFFF_FF00));
    push_word(make_search('1));
    push_word(make_search(64'h8000_0000_0000_0000));
    wait_drained();
    set_count(2);
    push_word(make_search('1));
    wait_drained();
    set_count(1);
    push_word(make_search(64'h100));
    push_word(make_search('0));

    // random phases, each with its own count setting
    phase = 0;
    while (words_queued < TARGET_WORDS) begin
      if (phase < 6) count = extremes[phase];
      else if ($urandom_range(0, 3) == 0) count = $urandom_range(65, 127);
      else count = $urandom_range(0, 64);
      wait_drained();
      set_count(count);
      n = (count > MAX_RANGES) ? MAX_RANGES : count;
      ready = 1'b1;
      for (i = 0; i < n; i++) if (!plan_written[i]) ready = 1'b0;
      if (n > 0 && (!ready || $urandom_range(0, 1) == 0)) build_table(n);
      if (phase == 2 || (!calm && $urandom_range(0, 9) == 0)) holds_asked++;
      ops = $urandom_range(20, 40);
      for (j = 0; j < ops; j++) begin
        if (j == ops / 2 && (phase == 1 || $urandom_range(0, 3) == 0)) wait_drained();
        // occasional stray write, which may leave the table unsorted
        if ($urandom_range(0, 9) == 0)
          push_word(make_write($urandom_range(0, 63), rnd64(), rnd64()));
        else
          push_word(make_search(pick_address(n)));
      end
      if (words_queued > TARGET_WORDS * 85 / 100) calm = 1'b1;
      phase++;
    end

    wait_drained();
    $display("run covered %0d table writes and %0d searches (%0d hits) over %0d count settings",
             writes_sent, searches_sent, hits_seen, settings_used);
    $display("counts from empty to saturated, unsorted tables, a long output hold-off and pauses");
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
